// ===== rtl/skt_pkg.sv =====
// shared widths, result codes, command and status types of the sorted key table
package skt_pkg;

  // default table depth
  localparam int CAPACITY_DEFAULT = 16;

  // item field widths
  localparam int KEY_W    = 31;
  localparam int PAY_W    = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;

  typedef logic [STATUS_W-1:0] status_t;

  // result status codes
  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_DUPLICATE = 3'd1;
  localparam status_t ST_FULL      = 3'd2;
  localparam status_t ST_LISTED    = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

  // operation codes of an input item
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LIST   = 1'b1;

  // memory read address select
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_MID    = 2'd0;
  localparam rd_sel_t RD_PTR    = 2'd1;
  localparam rd_sel_t RD_PTR_M1 = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic    capture;      // latch item, open search window
    logic    search_step;  // narrow window from compare result
    logic    shift_init;   // start shift pointer at the entry count
    logic    shift_write;  // move read entry up one slot, step pointer down
    logic    write_new;    // store the new entry at its slot, bump count
    logic    list_init;    // start list pointer at slot zero
    logic    ptr_inc;      // advance list pointer
    logic    out_load;     // load output register
    rd_sel_t rd_sel;
    status_t out_status;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic search_done;
    logic key_eq;
    logic ptr_above;
    logic list_last;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/skt_in_if.sv =====
// input channel of the sorted key table
interface skt_in_if;
  import skt_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output operation, output key, output payload, input ready);
  modport sink (input valid, input operation, input key, input payload, output ready);
endinterface

// ===== rtl/skt_out_if.sv =====
// result channel of the sorted key table
interface skt_out_if;
  import skt_pkg::*;

  logic             valid;
  logic             ready;
  status_t          status;
  logic [POS_W-1:0] position;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_payload;
  logic             last;

  modport source (output valid, output status, output position, output out_key,
                  output out_payload, output last, input ready);
  modport sink (input valid, input status, input position, input out_key,
                input out_payload, input last, output ready);
endinterface

// ===== rtl/skt_datapath.sv =====
// table memories, search window, pointers and output register
module skt_datapath import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [KEY_W-1:0] in_key,
  input  logic [PAY_W-1:0] in_payload,
  output logic             out_valid,
  input  logic             out_ready,
  output status_t          out_status,
  output logic [POS_W-1:0] out_position,
  output logic [KEY_W-1:0] out_key,
  output logic [PAY_W-1:0] out_payload,
  output logic             out_last
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [PAY_W-1:0] pay_mem [CAPACITY];

  logic [KEY_W-1:0] op_key;
  logic [PAY_W-1:0] op_pay;
  logic [CW-1:0]    entry_count;
  logic [CW-1:0]    lo;
  logic [CW-1:0]    hi;
  logic [CW-1:0]    ptr;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;

  logic [CW:0]      win_sum;
  logic [CW-1:0]    mid;
  logic [CW-1:0]    ptr_m1;
  logic [CW:0]      ptr_p1;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_key;
  logic [PAY_W-1:0] wr_pay;

  // midpoint of the search window and pointer neighbors
  assign win_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = win_sum[CW:1];
  assign ptr_m1  = ptr - CW'(1);
  assign ptr_p1  = {1'b0, ptr} + (CW+1)'(1);

  // read address select
  always_comb begin
    case (cmd.rd_sel)
      RD_MID:    rd_addr = mid[AW-1:0];
      RD_PTR:    rd_addr = ptr[AW-1:0];
      RD_PTR_M1: rd_addr = ptr_m1[AW-1:0];
      default:   rd_addr = ptr[AW-1:0];
    endcase
  end

  // write port: shifted entry or new entry
  always_comb begin
    wr_en   = cmd.shift_write | cmd.write_new;
    wr_addr = cmd.write_new ? lo[AW-1:0] : ptr[AW-1:0];
    wr_key  = cmd.write_new ? op_key : rd_key;
    wr_pay  = cmd.write_new ? op_pay : rd_pay;
  end

  // table memories with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    rd_key <= key_mem[rd_addr];
    rd_pay <= pay_mem[rd_addr];
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_key <= in_key;
      op_pay <= in_payload;
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.write_new) begin
      entry_count <= entry_count + CW'(1);
    end
  end

  // search window; a hit collapses the window onto the matching slot
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lo <= '0;
      hi <= entry_count;
    end else if (cmd.search_step) begin
      if (op_key == rd_key) begin
        lo <= mid;
        hi <= mid;
      end else if (op_key < rd_key) begin
        hi <= mid;
      end else begin
        lo <= mid + CW'(1);
      end
    end
  end

  // shift and list pointer
  always_ff @(posedge clk) begin
    if (cmd.shift_init) begin
      ptr <= entry_count;
    end else if (cmd.list_init) begin
      ptr <= '0;
    end else if (cmd.shift_write) begin
      ptr <= ptr_m1;
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_p1[CW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      case (cmd.out_status)
        ST_INSERTED, ST_DUPLICATE: begin
          out_position <= POS_W'(lo);
          out_key      <= op_key;
          out_payload  <= '0;
          out_last     <= 1'b1;
        end
        ST_FULL: begin
          out_position <= '0;
          out_key      <= op_key;
          out_payload  <= '0;
          out_last     <= 1'b1;
        end
        ST_LISTED: begin
          out_position <= POS_W'(ptr);
          out_key      <= rd_key;
          out_payload  <= rd_pay;
          out_last     <= sts.list_last;
        end
        default: begin
          out_position <= '0;
          out_key      <= '0;
          out_payload  <= '0;
          out_last     <= 1'b1;
        end
      endcase
    end
  end

  // status to controller
  always_comb begin
    sts.full        = (entry_count == CW'(CAPACITY));
    sts.empty       = (entry_count == '0);
    sts.search_done = (lo >= hi);
    sts.key_eq      = (op_key == rd_key);
    sts.ptr_above   = (ptr > lo);
    sts.list_last   = (ptr_p1 == {1'b0, entry_count});
    sts.out_free    = !out_valid || out_ready;
  end

endmodule

// ===== rtl/skt_controller.sv =====
// sequencer for search, shift, insert and listing
module skt_controller import skt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_operation,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SRCH_RD   = 3'd1;
  localparam logic [2:0] S_SRCH_CMP  = 3'd2;
  localparam logic [2:0] S_SHIFT_CHK = 3'd3;
  localparam logic [2:0] S_SHIFT_WR  = 3'd4;
  localparam logic [2:0] S_EMIT      = 3'd5;
  localparam logic [2:0] S_LIST_RD   = 3'd6;
  localparam logic [2:0] S_LIST_EMIT = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  status_t    res;
  status_t    res_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next     = state;
    res_next       = res;
    cmd            = '0;
    cmd.rd_sel     = RD_PTR;
    cmd.out_status = res;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (in_operation == OP_LIST) begin
            if (sts.empty) begin
              res_next   = ST_EMPTY;
              state_next = S_EMIT;
            end else begin
              cmd.list_init = 1'b1;
              state_next    = S_LIST_RD;
            end
          end else if (sts.full) begin
            res_next   = ST_FULL;
            state_next = S_EMIT;
          end else begin
            state_next = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: begin
        cmd.rd_sel = RD_MID;
        if (sts.search_done) begin
          cmd.shift_init = 1'b1;
          state_next     = S_SHIFT_CHK;
        end else begin
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.search_step = 1'b1;
        if (sts.key_eq) begin
          res_next   = ST_DUPLICATE;
          state_next = S_EMIT;
        end else begin
          state_next = S_SRCH_RD;
        end
      end
      S_SHIFT_CHK: begin
        cmd.rd_sel = RD_PTR_M1;
        if (sts.ptr_above) begin
          state_next = S_SHIFT_WR;
        end else begin
          cmd.write_new = 1'b1;
          res_next      = ST_INSERTED;
          state_next    = S_EMIT;
        end
      end
      S_SHIFT_WR: begin
        cmd.shift_write = 1'b1;
        state_next      = S_SHIFT_CHK;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_LIST_RD: begin
        state_next = S_LIST_EMIT;
      end
      S_LIST_EMIT: begin
        cmd.out_status = ST_LISTED;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.ptr_inc  = 1'b1;
          state_next   = sts.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res   <= ST_INSERTED;
    end else begin
      state <= state_next;
      res   <= res_next;
    end
  end

  // output register is never overwritten while a result waits
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register loaded while occupied");

  // a new entry is never stored into a full table
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.write_new |-> !sts.full)
    else $error("insert into full table");

  // a compare always follows the read of the midpoint
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH_CMP) |-> ($past(state) == S_SRCH_RD))
    else $error("search compare without midpoint read");

  // a shift write only moves an entry read in the check before it
  a_shift_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT_WR) |-> ($past(state) == S_SHIFT_CHK && $past(sts.ptr_above)))
    else $error("shift write out of sequence");

endmodule

// ===== rtl/sorted_key_table_insert_scan_unit.sv =====
// top level of the sorted key table: binary-search insert and ordered listing
//
//   channel  role    fields
//   req      sink    operation, key, payload
//   rsp      source  status, position, out_key, out_payload, last
//
// An insert: accept, a midpoint read and compare per search probe (at most
// log2(CAPACITY)+1), search close, a check and write per shifted entry, a store
// and result load; a duplicate loads after its hit, full table or empty listing
// after accept. Listing: accept, a read and load per entry (single read port).
// Reset clears the entry count and control only; the table needs no clearing.
// A stalled result channel holds the sequencer before the next result load.
module sorted_key_table_insert_scan_unit import skt_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  skt_in_if.sink    req,
  skt_out_if.source rsp
);

  cmd_t cmd;
  sts_t sts;

  skt_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_operation (req.operation),
    .in_ready     (req.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  skt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_key       (req.key),
    .in_payload   (req.payload),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .out_status   (rsp.status),
    .out_position (rsp.position),
    .out_key      (rsp.out_key),
    .out_payload  (rsp.out_payload),
    .out_last     (rsp.last)
  );

endmodule

// ===== dv/sorted_key_table_insert_scan_unit_tb.sv =====
// testbench of the sorted key table: directed and random inserts and listings
module sorted_key_table_insert_scan_unit_tb;
  import skt_pkg::*;

  localparam int TABLE_DEPTH     = CAPACITY_DEFAULT;
  localparam int IDLE_MAX        = 12;
  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 60;
  localparam int TOTAL_ITEMS     = 300;
  localparam logic [KEY_W-1:0] KEY_MAX = '1;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic             last;
  } table_result_t;

  logic clk;
  logic rst;

  skt_in_if  req_if();
  skt_out_if rsp_if();

  sorted_key_table_insert_scan_unit #(.CAPACITY(TABLE_DEPTH)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  // shadow copy of the table and the results still owed by the block
  logic [KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [PAY_W-1:0] shadow_pays [TABLE_DEPTH];
  int               shadow_count = 0;
  table_result_t    owed_results [$];

  int fail_count   = 0;
  int items_sent   = 0;
  int req_idle_max = IDLE_MAX;
  int rsp_idle_max = IDLE_MAX;
  int hold_cycles  = 0;
  int rsp_wait     = 0;
  int quiet_cycles = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // apply one accepted item to the shadow table and queue what it must produce
  function automatic void predict_table_op(logic op, logic [KEY_W-1:0] key,
                                           logic [PAY_W-1:0] pay);
    int            lo;
    int            hi;
    int            mid;
    int            i;
    bit            found;
    table_result_t res;
    res = '0;
    res.last = 1'b1;
    if (op == OP_INSERT) begin
      res.key = key;
      if (shadow_count >= TABLE_DEPTH) begin
        // full table wins over the key search
        res.status = ST_FULL;
      end else begin
        lo = 0;
        hi = shadow_count;
        found = 1'b0;
        while (lo < hi && !found) begin
          mid = (lo + hi) / 2;
          if (key == shadow_keys[mid]) begin
            found = 1'b1;
            lo = mid;
          end else if (key < shadow_keys[mid]) begin
            hi = mid;
          end else begin
            lo = mid + 1;
          end
        end
        res.position = lo[POS_W-1:0];
        if (found) begin
          res.status = ST_DUPLICATE;
        end else begin
          // open the slot by moving higher entries up one place
          for (i = shadow_count; i > lo; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[lo] = key;
          shadow_pays[lo] = pay;
          shadow_count++;
          res.status = ST_INSERTED;
        end
      end
      owed_results.push_back(res);
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
      owed_results.push_back(res);
    end else begin
      for (i = 0; i < shadow_count; i++) begin
        res.status   = ST_LISTED;
        res.position = i[POS_W-1:0];
        res.key      = shadow_keys[i];
        res.payload  = shadow_pays[i];
        res.last     = (i == shadow_count - 1);
        owed_results.push_back(res);
      end
    end
  endfunction

  // offer one item after a random gap, returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay);
    int gap;
    gap = $urandom_range(0, req_idle_max);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.key       <= key;
    req_if.payload   <= pay;
    do @(posedge clk); while (!req_if.ready);
    predict_table_op(op, key, pay);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every owed result has come back
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  // keys cluster at both ends, repeat stored ones, or spread over the range
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 4))
      0: k = KEY_W'($urandom_range(0, 63));
      1: k = KEY_MAX - KEY_W'($urandom_range(0, 63));
      2: begin
        if (shadow_count > 0) k = shadow_keys[$urandom_range(0, shadow_count - 1)];
        else k = KEY_W'($urandom());
      end
      default: k = KEY_W'($urandom());
    endcase
    return k;
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    logic [PAY_W-1:0] p;
    case ($urandom_range(0, 5))
      0: p = '0;
      1: p = '1;
      default: p = $urandom();
    endcase
    return p;
  endfunction

  function automatic logic pick_op(int list_weight);
    return ($urandom_range(0, 99) < list_weight) ? OP_LIST : OP_INSERT;
  endfunction

  function automatic void check_field(string name, logic [PAY_W-1:0] want,
                                      logic [PAY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // result ready with a random stall after each result and an optional long hold-off
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cycles--;
      end else if (rsp_wait > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_wait--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest owed one
  always @(posedge clk) begin : result_check
    table_result_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      rsp_wait = $urandom_range(0, rsp_idle_max);
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: status %0d position %0d key 'h%0h",
               rsp_if.status, rsp_if.position, rsp_if.out_key);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("status", PAY_W'(want.status), PAY_W'(rsp_if.status));
        check_field("position", PAY_W'(want.position), PAY_W'(rsp_if.position));
        check_field("out_key", PAY_W'(want.key), PAY_W'(rsp_if.out_key));
        check_field("out_payload", want.payload, rsp_if.out_payload);
        check_field("last", PAY_W'(want.last), PAY_W'(rsp_if.last));
      end
    end
  end

  // watchdog on cycles in which no item moves on either channel
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no item moved for %0d cycles", STALL_LIMIT);
      $display("sorted_key_table_insert_scan_unit verification failed");
      $finish;
    end
  end

  // empty listing, key and payload extremes, duplicates at both ends
  task automatic test_empty_and_extremes();
    send_item(OP_LIST, '0, '0);
    send_item(OP_INSERT, '0, '1);
    send_item(OP_INSERT, KEY_MAX, '0);
    send_item(OP_INSERT, 31'h2AAAAAAA, 32'h55555555);
    send_item(OP_INSERT, 31'h55555555, 32'hAAAAAAAA);
    send_item(OP_INSERT, '0, 32'h12345678);
    send_item(OP_INSERT, KEY_MAX, 32'h9ABCDEF0);
    send_item(OP_LIST, KEY_MAX, '1);
  endtask

  // random inserts with duplicates and listings until the table fills
  task automatic test_fill_random();
    while (shadow_count < TABLE_DEPTH)
      send_item(pick_op(20), pick_key(), pick_payload());
  endtask

  // full table rejects new and already stored keys alike
  task automatic test_full_table();
    send_item(OP_INSERT, 31'h1234567, 32'hCAFE0001);
    send_item(OP_INSERT, shadow_keys[TABLE_DEPTH/2], 32'hCAFE0002);
    send_item(OP_INSERT, shadow_keys[0], '1);
    send_item(OP_LIST, '0, '0);
  endtask

  // both sides with no idling at all
  task automatic test_back_to_back();
    req_idle_max = 0;
    rsp_idle_max = 0;
    repeat (30) send_item(pick_op(50), pick_key(), pick_payload());
    req_idle_max = IDLE_MAX;
    rsp_idle_max = IDLE_MAX;
  endtask

  // receiver holds off while listings keep coming, then the sender waits it out
  task automatic test_result_hold_off();
    hold_cycles = HOLD_OFF_CYCLES;
    req_idle_max = 0;
    repeat (6) send_item(OP_LIST, pick_key(), pick_payload());
    req_idle_max = IDLE_MAX;
    wait_drained();
  endtask

  // random mix on the full table with an occasional full drain
  task automatic test_random_mix();
    while (items_sent < TOTAL_ITEMS) begin
      send_item(pick_op(50), pick_key(), pick_payload());
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_if.valid     = 1'b0;
    req_if.operation = OP_INSERT;
    req_if.key       = '0;
    req_if.payload   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_and_extremes();
    test_fill_random();
    test_full_table();
    test_back_to_back();
    test_result_hold_off();
    test_random_mix();

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("sorted_key_table_insert_scan_unit verification clean");
    end else begin
      $display("sorted_key_table_insert_scan_unit verification failed");
    end
    $finish;
  end

endmodule
